[hdl/mmd_pkg.sv]
package mmd_pkg;

    localparam int CHANNELS    = 6;
    localparam int SAMPLE_BITS = 12;

    typedef logic [SAMPLE_BITS-1:0] t_sample;
    typedef t_sample [CHANNELS-1:0] t_chan_arr;

    typedef struct packed {
        t_sample sample_ch0;
        t_sample sample_ch1;
        t_sample sample_ch2;
        t_sample sample_ch3;
        t_sample sample_ch4;
        t_sample sample_ch5;
    } t_scan;

    typedef struct packed {
        t_sample median_ch0;
        t_sample median_ch1;
        t_sample median_ch2;
        t_sample median_ch3;
        t_sample median_ch4;
        t_sample median_ch5;
    } t_median;

    function automatic t_chan_arr scan_to_arr(t_scan s);
        t_chan_arr a;
        a[0] = s.sample_ch0;
        a[1] = s.sample_ch1;
        a[2] = s.sample_ch2;
        a[3] = s.sample_ch3;
        a[4] = s.sample_ch4;
        a[5] = s.sample_ch5;
        return a;
    endfunction

    function automatic t_median arr_to_median(t_chan_arr a);
        t_median m;
        m.median_ch0 = a[0];
        m.median_ch1 = a[1];
        m.median_ch2 = a[2];
        m.median_ch3 = a[3];
        m.median_ch4 = a[4];
        m.median_ch5 = a[5];
        return m;
    endfunction

endpackage

[hdl/mmd_front.sv]
module mmd_front #(
    parameter int WINDOW = 7
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  mmd_pkg::t_scan i_scan,
    input  logic           i_full,
    output logic           o_push,
    output logic [mmd_pkg::CHANNELS-1:0][WINDOW-1:0][mmd_pkg::SAMPLE_BITS-1:0] o_win
);
    import mmd_pkg::*;

    localparam int FILL_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam logic [FILL_W-1:0] LAST = FILL_W'(WINDOW - 1);

    t_chan_arr   w_samp;
    logic        w_acc;
    logic        w_last;
    logic [FILL_W-1:0] r_fill, n_fill;
    logic [CHANNELS-1:0][WINDOW-1:0][SAMPLE_BITS-1:0] r_win, n_win;

    always_comb begin
        w_samp = scan_to_arr(i_scan);
        n_win  = r_win;
        for (int ch = 0; ch < CHANNELS; ch++) begin
            n_win[ch][r_fill] = w_samp[ch];
        end
        w_acc  = i_valid && !i_full;
        w_last = (r_fill == LAST);
        n_fill = w_last ? '0 : r_fill + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else if (w_acc) begin
            r_fill <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_win <= n_win;
        end
    end

    assign o_stall = i_full;
    assign o_push  = w_acc && w_last;
    assign o_win   = n_win;

endmodule

[hdl/mmd_queue.sv]
module mmd_queue #(
    parameter int DATA_W = 504
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [DATA_W-1:0] i_data,
    output logic              o_full,
    output logic              o_valid,
    output logic [DATA_W-1:0] o_data,
    input  logic              i_pop
);
    logic [DATA_W-1:0] r_mem [2];
    logic              r_wr;
    logic              r_rd;
    logic [1:0]        r_count;
    logic              w_push;
    logic              w_pop;

    assign w_push = i_push && (r_count != 2'd2);
    assign w_pop  = i_pop && (r_count != 2'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr <= ~r_wr;
            end
            if (w_pop) begin
                r_rd <= ~r_rd;
            end
            case ({w_push, w_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_data  = r_mem[r_rd];

endmodule

[hdl/mmd_back.sv]
module mmd_back #(
    parameter int WINDOW = 7
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_valid,
    input  logic [mmd_pkg::CHANNELS-1:0][WINDOW-1:0][mmd_pkg::SAMPLE_BITS-1:0] i_q_data,
    output logic              o_pop,
    output logic              o_valid,
    input  logic              i_stall,
    output mmd_pkg::t_median  o_median
);
    import mmd_pkg::*;

    localparam int FILL_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CNT_W  = $clog2(WINDOW + 1);
    localparam logic [FILL_W-1:0] LAST = FILL_W'(WINDOW - 1);
    localparam logic [CNT_W-1:0]  HALF = CNT_W'(WINDOW / 2);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_SEND
    } t_state;

    t_state      r_state;
    logic [FILL_W-1:0] r_cnt;
    logic [CHANNELS-1:0][WINDOW-1:0][SAMPLE_BITS-1:0] r_work, n_rot;
    t_chan_arr   r_med;
    t_median     r_out;
    logic        r_out_valid;
    logic [CHANNELS-1:0][CNT_W-1:0] w_lt, w_le;
    logic [CHANNELS-1:0] w_hit;
    logic        w_send;

    // candidate is slot 0; it is the median when at most HALF entries are
    // below it and more than HALF are at or below it
    always_comb begin
        for (int ch = 0; ch < CHANNELS; ch++) begin
            w_lt[ch] = '0;
            w_le[ch] = '0;
            for (int k = 0; k < WINDOW; k++) begin
                w_lt[ch] = w_lt[ch] + CNT_W'(r_work[ch][k] < r_work[ch][0]);
                w_le[ch] = w_le[ch] + CNT_W'(r_work[ch][k] <= r_work[ch][0]);
                n_rot[ch][k] = r_work[ch][(k + 1) % WINDOW];
            end
            w_hit[ch] = (w_lt[ch] <= HALF) && (w_le[ch] > HALF);
        end
    end

    assign w_send = !r_out_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if ((r_state == S_SEND) && w_send) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_work  <= i_q_data;
                        r_cnt   <= '0;
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    for (int ch = 0; ch < CHANNELS; ch++) begin
                        if (w_hit[ch]) begin
                            r_med[ch] <= r_work[ch][0];
                        end
                    end
                    r_work <= n_rot;
                    r_cnt  <= r_cnt + 1'b1;
                    if (r_cnt == LAST) begin
                        r_state <= S_SEND;
                    end
                end
                S_SEND: begin
                    if (w_send) begin
                        r_out   <= arr_to_median(r_med);
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_pop    = (r_state == S_IDLE) && i_q_valid;
    assign o_valid  = r_out_valid;
    assign o_median = r_out;

endmodule

[hdl/multichannel_median_decimator_top.sv]
// Block median decimator over CHANNELS converter channels.
// Input channel: one scan word (six 12-bit samples) per accepted i_valid
// with o_stall low. Output channel: one median word per WINDOW scans, on
// o_valid, taken when i_stall is low.
// Scans are taken one per cycle while the window queue has room. The scan
// that completes a window pushes the whole window into a two-entry queue.
// The median unit pops a window and checks one candidate per channel each
// cycle, then sends the result and returns to idle to pop the next window.
// Scans keep arriving while a window is in the median unit, and the queue
// takes up the difference; with the output free, a burst of six windows
// (at WINDOW = 7) is taken at one scan per cycle before the queue fills.
// A completing scan reaches o_valid through the queue, the pop, the candidate
// scan and the send state, when the median unit is idle.
// A stalled output holds its word; the median unit then waits with the
// next result, the queue fills and o_stall rises.
// Reset clears the window count, the queue and the output valid.
module multichannel_median_decimator_top #(
    parameter int WINDOW = 7
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  mmd_pkg::t_scan   i_scan,
    output logic             o_valid,
    input  logic             i_stall,
    output mmd_pkg::t_median o_median
);
    import mmd_pkg::*;

    localparam int DATA_W = CHANNELS * WINDOW * SAMPLE_BITS;

    logic w_push;
    logic w_full;
    logic w_q_valid;
    logic w_pop;
    logic [CHANNELS-1:0][WINDOW-1:0][SAMPLE_BITS-1:0] w_win, w_q_data;

    mmd_front #(.WINDOW(WINDOW)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_scan  (i_scan),
        .i_full  (w_full),
        .o_push  (w_push),
        .o_win   (w_win)
    );

    mmd_queue #(.DATA_W(DATA_W)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_win),
        .o_full  (w_full),
        .o_valid (w_q_valid),
        .o_data  (w_q_data),
        .i_pop   (w_pop)
    );

    mmd_back #(.WINDOW(WINDOW)) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (w_q_valid),
        .i_q_data  (w_q_data),
        .o_pop     (w_pop),
        .o_valid   (o_valid),
        .i_stall   (i_stall),
        .o_median  (o_median)
    );

    a_push_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |=> w_q_valid)
        else $error("pushed window not visible in queue");

    a_pop_spaced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |=> !w_pop)
        else $error("median unit popped twice in a row");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_q_valid)
        else $error("pop from empty queue");

endmodule
